// File: rtl/rcfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfd_pkg
// Types, frame position codes and the prelude table of the ROM read command
// frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

   typedef logic [3:0] pos_type;

   localparam int unsigned PRELUDE_LEN = 8;

   // Positions 0 to 7 count matched prelude offsets; 8 to 12 name the next
   // word to capture.
   localparam pos_type POS_SEARCH   = 4'd0;
   localparam pos_type POS_MAGIC_HI = 4'd8;
   localparam pos_type POS_MAGIC_LO = 4'd9;
   localparam pos_type POS_CMD      = 4'd10;
   localparam pos_type POS_PARAM    = 4'd11;
   localparam pos_type POS_CHECK    = 4'd12;

   localparam logic [15:0] SUM_MASK = 16'hFFFE;

   typedef struct packed {
      logic        checksum_good;
      logic [31:0] magic_value;
      logic [15:0] command_code;
      logic [14:0] parameter_value;
   } result_type;

   function automatic logic [15:0] prelude_word(input logic [2:0] idx);
      logic [15:0] word;
      unique case (idx)
         3'd0: word = 16'h1234;
         3'd1: word = 16'hFC42;
         3'd2: word = 16'h6452;
         3'd3: word = 16'hCDE0;
         3'd4: word = 16'h5CA2;
         3'd5: word = 16'h8CA4;
         3'd6: word = 16'h1F94;
         3'd7: word = 16'hE642;
         default: word = 16'h1234;
      endcase
      return word;
   endfunction

endpackage
`default_nettype wire

// File: rtl/rcfd_frame_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfd_frame_tracker
// Tracks the frame position, matches the prelude, captures the four frame
// words and forms the result when the checksum word arrives.
// ----------------------------------------------------------------------------
module rcfd_frame_tracker
   import rcfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic [15:0] offset,
   output logic             at_check,
   output result_type       result
);

   pos_type     pos_ff, pos_in, pos_eff;
   logic [15:0] magic_hi_ff, magic_lo_ff, command_ff, param_ff;
   logic [15:0] sum;

   // Unreachable positions behave as a fresh search.
   assign pos_eff  = (pos_ff > POS_CHECK) ? POS_SEARCH : pos_ff;
   assign at_check = (pos_eff == POS_CHECK);

   always_comb begin
      pos_in = pos_eff;
      if (pos_eff < POS_MAGIC_HI) begin
         if (offset == prelude_word(pos_eff[2:0])) begin
            pos_in = pos_eff + 4'd1;
         end else if (offset == prelude_word(3'd0)) begin
            pos_in = 4'd1;
         end else begin
            pos_in = POS_SEARCH;
         end
      end else if (at_check) begin
         pos_in = POS_SEARCH;
      end else begin
         pos_in = pos_eff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_SEARCH;
      end else if (step) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         if (pos_eff == POS_MAGIC_HI) magic_hi_ff <= offset;
         if (pos_eff == POS_MAGIC_LO) magic_lo_ff <= offset;
         if (pos_eff == POS_CMD)      command_ff  <= offset;
         if (pos_eff == POS_PARAM)    param_ff    <= offset;
      end
   end

   assign sum = magic_hi_ff + magic_lo_ff + command_ff + param_ff;

   always_comb begin
      result.checksum_good   = ((sum & SUM_MASK) == offset);
      result.magic_value     = {magic_hi_ff, magic_lo_ff};
      result.command_code    = command_ff;
      result.parameter_value = param_ff[15:1];
   end

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_CHECK)
      else $error("frame position left the valid range");

   a_check_restarts: assert property (@(posedge clock) disable iff (reset)
      step && at_check |=> pos_ff == POS_SEARCH)
      else $error("position did not restart after the checksum word");

   a_capture_advances: assert property (@(posedge clock) disable iff (reset)
      step && pos_eff >= POS_MAGIC_HI && !at_check |=> pos_ff == $past(pos_eff) + 4'd1)
      else $error("capture phase did not advance by one word");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(pos_ff))
      else $error("frame position moved without an item");

endmodule
`default_nettype wire

// File: rtl/rom_read_command_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rom_read_command_frame_decoder
// Decodes a command frame sent as a sequence of ROM read offsets.
//
// The req channel carries one 16-bit read offset per item. After a prelude
// of eight fixed offsets, the next five items are taken as magic high, magic
// low, command, parameter and checksum. The item carrying the checksum word
// produces one rsp item with the magic, the command, the parameter halved
// and a checksum flag; all other items produce nothing.
//
// An accepted item is held in an input register and is processed as it leaves
// it; a checksum item then loads its result into the rsp register, which
// drives rsp_valid. One item per cycle is sustained unless a checksum item
// waits on a stalled receiver: the input register and the rsp register each
// take a new entry whenever empty or being emptied in the same cycle.
// When the receiver stalls with a result pending, the input register holds
// only if it too carries a checksum word; other items keep flowing.
// Synchronous reset empties both registers and restarts the prelude search.
// ----------------------------------------------------------------------------
module rom_read_command_frame_decoder
   import rcfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_bus_offset,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_checksum_good,
   output logic [31:0]      rsp_magic_value,
   output logic [15:0]      rsp_command_code,
   output logic [14:0]      rsp_parameter_value
);

   logic        s1_valid_ff;
   logic [15:0] s1_offset_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;
   logic        at_check;
   result_type  result;
   logic        out_free;
   logic        s1_advance;

   rcfd_frame_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .step     (s1_advance),
      .offset   (s1_offset_ff),
      .at_check (at_check),
      .result   (result)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && (!at_check || out_free);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_offset_ff <= req_bus_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_advance && at_check;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_advance && at_check) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_checksum_good   = rsp_ff.checksum_good;
   assign rsp_magic_value     = rsp_ff.magic_value;
   assign rsp_command_code    = rsp_ff.command_code;
   assign rsp_parameter_value = rsp_ff.parameter_value;

endmodule
`default_nettype wire
